// File: rtl/ast_pkg.sv
package ast_pkg;

    localparam int ARG_W        = 32;
    localparam int TERM_W       = 11;
    localparam int RESULT_W     = 32;
    localparam int MAX_TERMS_DEF = 1024;
    localparam int FRAC_BITS_DEF = 30;

    typedef struct packed {
        logic signed [ARG_W-1:0]  argument;
        logic        [TERM_W-1:0] term_count;
    } request_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] result;
        logic                       saturated;
    } response_t;

endpackage

// File: rtl/arcsin_taylor_series_core.sv
// Arcsine by its Maclaurin series, fixed point with FRAC_BITS fraction bits.
// Input channel: a transaction is taken at a rising edge with start high and
// busy low; request carries the argument x (clamped to [-1,1]) and the term
// count n (clamped to MAX_TERMS). busy stays high until the result is out.
// Output channel: done is high for exactly one cycle with response valid;
// the receiver must take it then, it cannot hold the block off.
// All work runs on one shared shift-add multiplier / restoring divider that
// retires one bit per cycle.
// Cost: x^2 takes one operation, each term four (ceil divide for the
// coefficient, two multiplies, one divide), then ST_FINISH raises done.
// One transaction at a time; busy low again in the cycle done is shown,
// so the next start may be taken right then.
// The sum is clipped to the 32-bit result range; saturated flags the clip.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and clears
// done; no transaction is in flight afterwards.
module arcsin_taylor_series_core #(
    parameter int MAX_TERMS = ast_pkg::MAX_TERMS_DEF,
    parameter int FRAC_BITS = ast_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ast_pkg::request_t  request,
    output logic               busy,
    output logic               done,
    output ast_pkg::response_t response
);

    localparam int MW    = FRAC_BITS + 1;
    localparam int IW    = $clog2(MAX_TERMS + 1);
    localparam int DW    = IW + 1;
    localparam int UW    = (MW > DW) ? MW : DW;
    localparam int CNTW  = $clog2(MW + 2);
    localparam int ACC_W = 33;
    localparam int EW    = (ACC_W > MW + 1) ? ACC_W : MW + 1;
    localparam int SW    = ((ACC_W > MW) ? ACC_W : MW) + 1;
    localparam int NW    = (ast_pkg::TERM_W > IW) ? ast_pkg::TERM_W : IW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_X2,
        ST_C_DIV,
        ST_P_MUL,
        ST_T_MUL,
        ST_T_DIV,
        ST_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [UW:0]        hi_reg, hi_next;
    logic [MW-1:0]      lo_reg, lo_next;
    logic [UW-1:0]      b_reg, b_next;
    logic [CNTW-1:0]    cnt_reg, cnt_next;
    logic [MW-1:0]      x2_reg, x2_next;
    logic [MW-1:0]      c_reg, c_next;
    logic [MW-1:0]      p_reg, p_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [IW-1:0]      term_reg, term_next;
    logic [IW-1:0]      n_reg, n_next;
    logic               neg_reg, neg_next;
    logic               done_reg, done_next;
    ast_pkg::response_t response_reg, response_next;

    logic               stepping;
    logic               is_div;
    logic [UW:0]        mul_sum;
    logic [UW:0]        div_shift;
    logic               div_ok;
    logic [UW:0]        step_hi;
    logic [MW-1:0]      step_lo;
    logic [2*MW-1:0]    prod;
    logic [MW-1:0]      prod_fx;
    logic [MW-1:0]      c_upd;
    logic [SW-1:0]      acc_sum;
    logic [ACC_W-1:0]   acc_upd;
    logic [IW-1:0]      term_inc;
    logic [EW-1:0]      arg_mag;
    logic [EW-1:0]      arg_clamp;
    logic [NW-1:0]      n_wide;
    logic [IW-1:0]      n_clamp;
    logic [31:0]        raw;

    assign stepping = (cnt_reg != CNTW'(MW));
    assign is_div   = (state_reg == ST_C_DIV) || (state_reg == ST_T_DIV);

    // shared unit: one multiply or divide bit per cycle
    assign mul_sum   = {1'b0, hi_reg[UW-1:0]} + (lo_reg[0] ? {1'b0, b_reg} : '0);
    assign div_shift = {hi_reg[UW-1:0], lo_reg[MW-1]};
    assign div_ok    = (div_shift >= {1'b0, b_reg});

    always_comb
    begin
        if (is_div)
        begin
            step_hi = div_ok ? (div_shift - {1'b0, b_reg}) : div_shift;
            step_lo = {lo_reg[MW-2:0], div_ok};
        end
        else
        begin
            step_hi = {1'b0, mul_sum[UW:1]};
            step_lo = {mul_sum[0], lo_reg[MW-1:1]};
        end
    end

    assign prod     = {hi_reg[MW-1:0], lo_reg};
    assign prod_fx  = prod[FRAC_BITS +: MW];
    assign c_upd    = c_reg - lo_reg - MW'(hi_reg != '0);
    assign acc_sum  = SW'(acc_reg) + SW'(lo_reg);
    assign acc_upd  = (acc_sum > (SW'(1) << 32)) ? (ACC_W'(1) << 32) : acc_sum[ACC_W-1:0];
    assign term_inc = term_reg + 1'b1;

    assign raw       = request.argument;
    assign arg_mag   = raw[31] ? EW'(33'h1_0000_0000 - {1'b0, raw}) : EW'(raw);
    assign arg_clamp = (arg_mag > (EW'(1) << FRAC_BITS)) ? (EW'(1) << FRAC_BITS) : arg_mag;
    assign n_wide    = NW'(request.term_count);
    assign n_clamp   = (n_wide > NW'(MAX_TERMS)) ? IW'(MAX_TERMS) : n_wide[IW-1:0];

    always_comb
    begin
        state_next    = state_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        b_next        = b_reg;
        cnt_next      = cnt_reg;
        x2_next       = x2_reg;
        c_next        = c_reg;
        p_next        = p_reg;
        acc_next      = acc_reg;
        term_next     = term_reg;
        n_next        = n_reg;
        neg_next      = neg_reg;
        done_next     = 1'b0;
        response_next = response_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    neg_next   = raw[31];
                    n_next     = n_clamp;
                    term_next  = IW'(1);
                    c_next     = MW'(1) << FRAC_BITS;
                    p_next     = arg_clamp[MW-1:0];
                    acc_next   = arg_clamp[ACC_W-1:0];
                    hi_next    = '0;
                    lo_next    = arg_clamp[MW-1:0];
                    b_next     = UW'(arg_clamp[MW-1:0]);
                    cnt_next   = '0;
                    state_next = ST_X2;
                end
            end
            ST_X2, ST_C_DIV, ST_P_MUL, ST_T_MUL, ST_T_DIV:
            begin
                if (stepping)
                begin
                    hi_next  = step_hi;
                    lo_next  = step_lo;
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    hi_next  = '0;
                    cnt_next = '0;
                    unique case (state_reg)
                        ST_X2:
                        begin
                            x2_next = prod_fx;
                            lo_next = c_reg;
                            b_next  = UW'({term_reg, 1'b0});
                            state_next = (n_reg == '0) ? ST_FINISH : ST_C_DIV;
                        end
                        ST_C_DIV:
                        begin
                            c_next     = c_upd;
                            lo_next    = p_reg;
                            b_next     = UW'(x2_reg);
                            state_next = ST_P_MUL;
                        end
                        ST_P_MUL:
                        begin
                            p_next     = prod_fx;
                            lo_next    = c_reg;
                            b_next     = UW'(prod_fx);
                            state_next = ST_T_MUL;
                        end
                        ST_T_MUL:
                        begin
                            lo_next    = prod_fx;
                            b_next     = UW'({term_reg, 1'b1});
                            state_next = ST_T_DIV;
                        end
                        default:
                        begin
                            acc_next = acc_upd;
                            if (term_reg == n_reg)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                term_next  = term_inc;
                                lo_next    = c_reg;
                                b_next     = UW'({term_inc, 1'b0});
                                state_next = ST_C_DIV;
                            end
                        end
                    endcase
                end
            end
            ST_FINISH:
            begin
                done_next = 1'b1;
                if (neg_reg)
                begin
                    response_next.saturated = (acc_reg > (ACC_W'(1) << 31));
                    response_next.result    = response_next.saturated ? 32'h8000_0000
                                                                      : -acc_reg[31:0];
                end
                else
                begin
                    response_next.saturated = (acc_reg > ACC_W'(32'h7FFF_FFFF));
                    response_next.result    = response_next.saturated ? 32'h7FFF_FFFF
                                                                      : acc_reg[31:0];
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            term_reg  <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            term_reg  <= term_next;
            n_reg     <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        b_reg        <= b_next;
        x2_reg       <= x2_next;
        c_reg        <= c_next;
        p_reg        <= p_next;
        acc_reg      <= acc_next;
        neg_reg      <= neg_next;
        response_reg <= response_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign response = response_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted but block not busy");

    a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (term_reg <= n_reg || n_reg == '0))
        else $error("term index ran past term count");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && response.saturated) |->
            (response.result == 32'sh7FFF_FFFF || response.result == 32'sh8000_0000))
        else $error("saturated flag without clipped result");

endmodule

// File: tb/tb_arcsin_taylor_series_core.sv
`timescale 1ns / 100ps

module tb_arcsin_taylor_series_core;

    localparam int          FRAC         = ast_pkg::FRAC_BITS_DEF;
    localparam logic [31:0] ONE_FX       = 32'h4000_0000;
    localparam logic [31:0] MINUS_ONE_FX = 32'hC000_0000;
    localparam logic [63:0] ACC_LIMIT    = 64'd1 << 32;
    localparam int          STALL_LIMIT  = 500000;
    localparam int          N_DIRECTED   = 18;
    localparam int          N_RANDOM     = 100;

    typedef struct packed {
        ast_pkg::request_t  req;
        logic               known;
        ast_pkg::response_t rsp;
    } vector_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    ast_pkg::request_t  request;
    logic               busy;
    logic               done;
    ast_pkg::response_t response;

    ast_pkg::response_t pending_arcsin[$];
    ast_pkg::response_t expected_rsp;
    vector_t            directed_vectors [0:N_DIRECTED-1];
    int                 mismatch_count = 0;
    int                 idle_cycles = 0;

    arcsin_taylor_series_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .done     (done),
        .response (response)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [63:0] fx_product(logic [63:0] a, logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        prod = prod >> FRAC;
        return prod[63:0];
    endfunction

    function automatic ast_pkg::response_t arcsin_series(ast_pkg::request_t req);
        logic [31:0] raw;
        logic        neg;
        logic [63:0] mag;
        logic [63:0] sq;
        logic [63:0] coef;
        logic [63:0] pw;
        logic [63:0] acc;
        logic [63:0] div;
        logic [63:0] term;
        logic [63:0] res;
        int unsigned n;
        ast_pkg::response_t rsp;
        raw  = req.argument;
        neg  = raw[31];
        mag  = neg ? (64'd1 << 32) - {32'd0, raw} : {32'd0, raw};
        n    = {21'd0, req.term_count};
        if (mag > {32'd0, ONE_FX})
            mag = {32'd0, ONE_FX};
        if (n > ast_pkg::MAX_TERMS_DEF)
            n = ast_pkg::MAX_TERMS_DEF;
        sq   = fx_product(mag, mag);
        coef = {32'd0, ONE_FX};
        pw   = mag;
        acc  = mag;
        rsp.saturated = 1'b0;
        for (int unsigned k = 1; k <= n; k++)
        begin
            div  = 64'(2 * k);
            coef = coef - (coef + div - 64'd1) / div;
            pw   = fx_product(pw, sq);
            term = fx_product(coef, pw) / (div + 64'd1);
            acc  = acc + term;
            if (acc > ACC_LIMIT)
                acc = ACC_LIMIT;
        end
        if (neg)
        begin
            if (acc > (64'd1 << 31))
            begin
                acc = 64'd1 << 31;
                rsp.saturated = 1'b1;
            end
            res = (64'd1 << 32) - acc;
        end
        else
        begin
            if (acc > 64'h7FFF_FFFF)
            begin
                acc = 64'h7FFF_FFFF;
                rsp.saturated = 1'b1;
            end
            res = acc;
        end
        rsp.result = res[31:0];
        return rsp;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 150);
    endfunction

    function automatic logic [31:0] pick_argument();
        int unsigned roll;
        logic [31:0] tmp;
        roll = $urandom_range(0, 9);
        if (roll < 4)
        begin
            tmp = $urandom_range(0, 32'h8000_0000);
            return tmp - ONE_FX;
        end
        else if (roll < 7)
            return $urandom;
        else if (roll < 9)
            tmp = ONE_FX - $urandom_range(0, 4095);
        else
            tmp = $urandom_range(0, 255);
        return $urandom_range(0, 1) ? -tmp : tmp;
    endfunction

    function automatic logic [10:0] pick_terms();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return 11'($urandom_range(0, 12));
        else if (roll < 98)
            return 11'($urandom_range(13, 60));
        else
            return 11'($urandom_range(61, 2047));
    endfunction

    task automatic send(ast_pkg::request_t req, logic known, ast_pkg::response_t typed,
                        int unsigned gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        pending_arcsin.push_back(known ? typed : arcsin_series(req));
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_arcsin.size() != 0);
    endtask

    // transaction checker
    always @(posedge clk)
    begin : response_check
        if (rst_n && done)
        begin
            if (pending_arcsin.size() == 0)
                report_mismatch("response with none pending", response.result, 32'd0);
            else
            begin
                expected_rsp = pending_arcsin.pop_front();
                if (response.result !== expected_rsp.result)
                    report_mismatch("result", response.result, expected_rsp.result);
                if (response.saturated !== expected_rsp.saturated)
                    report_mismatch("saturated", {31'd0, response.saturated},
                                    {31'd0, expected_rsp.saturated});
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout with %0d transactions outstanding", pending_arcsin.size());
            $display("FAIL arcsin_taylor_series_core");
            $finish;
        end
    end

    initial
    begin : stimulus
        ast_pkg::request_t req;
        rst_n          = 1'b0;
        start          = 1'b0;
        request        = '0;

        directed_vectors = '{
            '{'{32'h0000_0000, 11'd0},    1'b1, '{32'h0000_0000, 1'b0}},
            '{'{ONE_FX, 11'd0},           1'b1, '{ONE_FX, 1'b0}},
            '{'{MINUS_ONE_FX, 11'd0},     1'b1, '{MINUS_ONE_FX, 1'b0}},
            '{'{32'h7FFF_FFFF, 11'd0},    1'b1, '{ONE_FX, 1'b0}},
            '{'{32'h8000_0000, 11'd0},    1'b1, '{MINUS_ONE_FX, 1'b0}},
            '{'{32'h0000_0000, 11'd5},    1'b1, '{32'h0000_0000, 1'b0}},
            '{'{ONE_FX, 11'd1},           1'b0, '0},
            '{'{MINUS_ONE_FX, 11'd1},     1'b0, '0},
            '{'{32'h0000_0001, 11'd3},    1'b0, '0},
            '{'{32'hFFFF_FFFF, 11'd3},    1'b0, '0},
            '{'{32'h2000_0000, 11'd20},   1'b0, '0},
            '{'{32'hE000_0000, 11'd20},   1'b0, '0},
            '{'{32'h4000_0001, 11'd4},    1'b0, '0},
            '{'{32'hBFFF_FFFF, 11'd4},    1'b0, '0},
            '{'{32'h3FFF_FFFF, 11'd64},   1'b0, '0},
            '{'{32'h5555_5555, 11'd10},   1'b0, '0},
            '{'{ONE_FX, 11'd2047},        1'b0, '0},
            '{'{MINUS_ONE_FX, 11'd1024},  1'b0, '0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send(directed_vectors[i].req, directed_vectors[i].known,
                 directed_vectors[i].rsp, pick_gap());
        drain();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
                drain();
            req.argument   = pick_argument();
            req.term_count = pick_terms();
            // every third block of 16 runs back to back
            send(req, 1'b0, '0, ((i / 16) % 3 == 1) ? 0 : pick_gap());
        end
        start <= 1'b0;

        while (pending_arcsin.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS arcsin_taylor_series_core");
        else
            $display("FAIL arcsin_taylor_series_core");
        $finish;
    end

endmodule
